@@ rtl/stt_pkg.sv @@
// ============================================================================
// Source text tokenizer package
// Shared types, token codes, character codes and the keyword table.
// ============================================================================
package stt_pkg;

    localparam int KEYWORD_CHARS_DEF = 8;
    localparam int OFFSET_BITS_DEF   = 32;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;
    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;

    typedef enum logic [5:0] {
        KIND_LPAREN      = 6'd0,
        KIND_RPAREN      = 6'd1,
        KIND_COMMA       = 6'd2,
        KIND_PLUS        = 6'd3,
        KIND_STAR        = 6'd4,
        KIND_MINUS       = 6'd5,
        KIND_SLASH       = 6'd6,
        KIND_LESS        = 6'd7,
        KIND_GREATER     = 6'd8,
        KIND_EQUAL       = 6'd9,
        KIND_SEMI        = 6'd10,
        KIND_PERCENT     = 6'd11,
        KIND_CARET       = 6'd12,
        KIND_LBRACE      = 6'd13,
        KIND_RBRACE      = 6'd14,
        KIND_DOT         = 6'd15,
        KIND_LBRACKET    = 6'd16,
        KIND_RBRACKET    = 6'd17,
        KIND_BANG        = 6'd18,
        KIND_KW_IF       = 6'd19,
        KIND_KW_PROGRAM  = 6'd20,
        KIND_KW_ELSE     = 6'd21,
        KIND_KW_WHILE    = 6'd22,
        KIND_KW_FOR      = 6'd23,
        KIND_KW_VAR      = 6'd24,
        KIND_KW_FUNCTION = 6'd25,
        KIND_KW_ANON     = 6'd26,
        KIND_KW_CLASS    = 6'd27,
        KIND_KW_EQ       = 6'd28,
        KIND_KW_OR       = 6'd29,
        KIND_KW_AND      = 6'd30,
        KIND_KW_NIL      = 6'd31,
        KIND_NUMBER      = 6'd32,
        KIND_IDENT       = 6'd33,
        KIND_STRING      = 6'd34,
        KIND_COMMENT     = 6'd35,
        KIND_BOOLEAN     = 6'd36,
        KIND_UNKNOWN     = 6'd37,
        KIND_END         = 6'd38
    } kind_t;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_NUMBER  = 5'b00010,
        MODE_WORD    = 5'b00100,
        MODE_STRING  = 5'b01000,
        MODE_COMMENT = 5'b10000
    } mode_t;

    typedef struct packed {
        logic       op;
        logic [7:0] char_byte;
    } byte_req_t;

    typedef struct packed {
        kind_t       token_kind;
        logic [31:0] token_start;
        logic [15:0] token_length;
        logic [30:0] number_value;
        logic        number_overflow;
        logic        bool_value;
        logic        last;
    } token_req_t;

    typedef struct packed {
        logic  hit;
        kind_t kind;
    } punct_t;

    // Keyword text is stored with its last character in the low byte.
    localparam int KW_COUNT   = 15;
    localparam int KW_MAX_LEN = 8;

    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("if"), 64'("program"), 64'("else"), 64'("while"), 64'("for"),
        64'("var"), 64'("function"), 64'("anon"), 64'("class"), 64'("eq"),
        64'("or"), 64'("and"), 64'("true"), 64'("false"), 64'("nil")
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd2, 4'd7, 4'd4, 4'd5, 4'd3, 4'd3, 4'd8, 4'd4, 4'd5, 4'd2,
        4'd2, 4'd3, 4'd4, 4'd5, 4'd3
    };

    localparam kind_t KW_KIND [KW_COUNT] = '{
        KIND_KW_IF, KIND_KW_PROGRAM, KIND_KW_ELSE, KIND_KW_WHILE, KIND_KW_FOR,
        KIND_KW_VAR, KIND_KW_FUNCTION, KIND_KW_ANON, KIND_KW_CLASS, KIND_KW_EQ,
        KIND_KW_OR, KIND_KW_AND, KIND_BOOLEAN, KIND_BOOLEAN, KIND_KW_NIL
    };

    localparam logic KW_BOOL [KW_COUNT] = '{
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b1, 1'b0, 1'b0
    };

    function automatic punct_t punct_decode(input logic [7:0] b);
        punct_t p;
        p.hit = 1'b1;
        unique case (b)
            8'h28:   p.kind = KIND_LPAREN;
            8'h29:   p.kind = KIND_RPAREN;
            8'h2C:   p.kind = KIND_COMMA;
            8'h2B:   p.kind = KIND_PLUS;
            8'h2A:   p.kind = KIND_STAR;
            8'h2D:   p.kind = KIND_MINUS;
            8'h2F:   p.kind = KIND_SLASH;
            8'h3C:   p.kind = KIND_LESS;
            8'h3E:   p.kind = KIND_GREATER;
            8'h3D:   p.kind = KIND_EQUAL;
            8'h3B:   p.kind = KIND_SEMI;
            8'h25:   p.kind = KIND_PERCENT;
            8'h5E:   p.kind = KIND_CARET;
            8'h7B:   p.kind = KIND_LBRACE;
            8'h7D:   p.kind = KIND_RBRACE;
            8'h2E:   p.kind = KIND_DOT;
            8'h5B:   p.kind = KIND_LBRACKET;
            8'h5D:   p.kind = KIND_RBRACKET;
            8'h21:   p.kind = KIND_BANG;
            default:
            begin
                p.hit  = 1'b0;
                p.kind = KIND_UNKNOWN;
            end
        endcase
        return p;
    endfunction

    function automatic token_req_t make_token(
        input kind_t       kind,
        input logic [31:0] start,
        input logic [15:0] length,
        input logic [30:0] value,
        input logic        overflow,
        input logic        bool_val
    );
        token_req_t t;
        t.token_kind      = kind;
        t.token_start     = start;
        t.token_length    = length;
        t.number_value    = value;
        t.number_overflow = overflow;
        t.bool_value      = bool_val;
        t.last            = 1'b0;
        return t;
    endfunction

endpackage

@@ rtl/source_text_tokenizer_core.sv @@
// ============================================================================
// Source text tokenizer core
// Scans a byte stream and produces punctuator, keyword, boolean, number,
// identifier, string, comment, unknown and end tokens.
// ============================================================================
// The byte channel carries one request per source byte, or an end-of-input
// request that flushes a pending number, identifier or keyword and then yields an end
// token. The token channel carries the resulting tokens in order; the last
// token produced by a byte request has its last bit set.
// Each byte request is handled in the cycle it is accepted and its tokens, at most
// two per byte request, are written into the registered token queue.
// A new byte request is taken every cycle while the four-entry token queue
// has room for two more tokens, so the rate is one byte per cycle as long as
// the receiver drains at least as many tokens as the text produces. When the
// receiver stalls, tokens collect in the queue and byte_stall rises once
// fewer than two entries are free; a stalled token request holds steady.
// Reset empties the queue, returns the scanner to idle between tokens and
// sets the byte offset to zero. An end-of-input request does the same to the
// scanner after its tokens are queued, so the next text starts at offset zero.
// ============================================================================
module source_text_tokenizer_core #(
    parameter int KEYWORD_CHARS = stt_pkg::KEYWORD_CHARS_DEF,
    parameter int OFFSET_BITS   = stt_pkg::OFFSET_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  stt_pkg::byte_req_t  byte_req,
    output logic                token_valid,
    input  logic                token_stall,
    output stt_pkg::token_req_t token_req
);

    localparam int IDX_W   = $clog2(KEYWORD_CHARS);
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam int KW_COUNT_W = stt_pkg::KW_COUNT;

    stt_pkg::mode_t           mode_reg, mode_next;
    logic [OFFSET_BITS-1:0]   pos_reg, pos_next;
    logic [OFFSET_BITS-1:0]   pstart_reg, pstart_next;
    logic [15:0]              plen_reg, plen_next;
    logic [30:0]              acc_reg, acc_next;
    logic                     ovf_reg, ovf_next;
    logic [7:0]               prefix_reg [KEYWORD_CHARS];

    logic                     prefix_we;
    logic [IDX_W-1:0]         prefix_idx;

    stt_pkg::token_req_t      queue_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]       count_reg;

    logic                     accept;
    logic                     pop;
    logic                     push0, push1;
    stt_pkg::token_req_t      res0, res1;

    logic [7:0]               b;
    logic                     is_digit, is_alpha, is_space;
    logic [3:0]               digit;
    logic [34:0]              num_sum;
    logic [15:0]              plen_inc;
    logic [KW_COUNT_W-1:0]    kw_hit;
    stt_pkg::token_req_t      num_tok, word_tok;
    stt_pkg::punct_t          punct;

    assign accept      = byte_valid && !byte_stall;
    assign pop         = token_valid && !token_stall;
    assign byte_stall  = count_reg > Q_CNT_W'(Q_DEPTH - 2);
    assign token_valid = count_reg != '0;
    assign token_req   = queue_reg[rd_ptr_reg];

    assign b        = byte_req.char_byte;
    assign is_digit = (b >= stt_pkg::CHAR_ZERO) && (b <= stt_pkg::CHAR_NINE);
    assign is_alpha = ((b >= stt_pkg::CHAR_LO_A) && (b <= stt_pkg::CHAR_LO_Z)) ||
                      ((b >= stt_pkg::CHAR_UP_A) && (b <= stt_pkg::CHAR_UP_Z));
    assign is_space = (b == stt_pkg::CHAR_SPACE) ||
                      ((b >= stt_pkg::CHAR_TAB) && (b <= stt_pkg::CHAR_CR));
    assign digit    = 4'(b - stt_pkg::CHAR_ZERO);
    assign num_sum  = 35'(acc_reg) * 35'd10 + 35'(digit);
    assign plen_inc = (plen_reg == stt_pkg::LEN_MAX) ? plen_reg : plen_reg + 16'd1;
    assign punct    = stt_pkg::punct_decode(b);

    always_comb
    begin
        for (int i = 0; i < stt_pkg::KW_COUNT; i++)
        begin
            kw_hit[i] = (plen_reg == 16'(stt_pkg::KW_LEN[i]));
            for (int j = 0; j < stt_pkg::KW_MAX_LEN; j++)
            begin
                if (j < int'(stt_pkg::KW_LEN[i]))
                begin
                    if (prefix_reg[IDX_W'(j)] !=
                        stt_pkg::KW_TEXT[i][8*(int'(stt_pkg::KW_LEN[i]) - 1 - j) +: 8])
                    begin
                        kw_hit[i] = 1'b0;
                    end
                end
            end
        end
    end

    always_comb
    begin
        num_tok  = stt_pkg::make_token(stt_pkg::KIND_NUMBER, 32'(pstart_reg), plen_reg,
                                       acc_reg, ovf_reg, 1'b0);
        word_tok = stt_pkg::make_token(stt_pkg::KIND_IDENT, 32'(pstart_reg), plen_reg,
                                       '0, 1'b0, 1'b0);
        for (int i = stt_pkg::KW_COUNT - 1; i >= 0; i--)
        begin
            if (kw_hit[i])
            begin
                word_tok.token_kind = stt_pkg::KW_KIND[i];
                word_tok.bool_value = stt_pkg::KW_BOOL[i];
            end
        end
    end

    always_comb
    begin
        logic                do_start;
        stt_pkg::token_req_t start_tok;
        logic                start_emit;

        mode_next   = mode_reg;
        pos_next    = pos_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        prefix_we   = 1'b0;
        prefix_idx  = plen_reg[IDX_W-1:0];
        push0       = 1'b0;
        push1       = 1'b0;
        res0        = num_tok;
        res1        = num_tok;
        do_start    = 1'b0;
        start_emit  = 1'b0;
        start_tok   = stt_pkg::make_token(stt_pkg::KIND_UNKNOWN, 32'(pos_reg), 16'd1,
                                          '0, 1'b0, 1'b0);

        if (byte_req.op == stt_pkg::OP_END)
        begin
            if (mode_reg == stt_pkg::MODE_NUMBER)
            begin
                push0 = 1'b1;
                res0  = num_tok;
            end
            else if (mode_reg == stt_pkg::MODE_WORD)
            begin
                push0 = 1'b1;
                res0  = word_tok;
            end
            if (push0)
            begin
                push1 = 1'b1;
                res1  = stt_pkg::make_token(stt_pkg::KIND_END, 32'(pos_reg), '0,
                                            '0, 1'b0, 1'b0);
            end
            else
            begin
                push0 = 1'b1;
                res0  = stt_pkg::make_token(stt_pkg::KIND_END, 32'(pos_reg), '0,
                                            '0, 1'b0, 1'b0);
            end
            mode_next   = stt_pkg::MODE_IDLE;
            pos_next    = '0;
            pstart_next = '0;
            plen_next   = '0;
            acc_next    = '0;
            ovf_next    = 1'b0;
        end
        else
        begin
            pos_next = pos_reg + OFFSET_BITS'(1);
            unique case (mode_reg)
                stt_pkg::MODE_NUMBER:
                begin
                    if (is_digit)
                    begin
                        if (num_sum > 35'(stt_pkg::NUM_MAX))
                        begin
                            acc_next = stt_pkg::NUM_MAX;
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = num_sum[30:0];
                        end
                        plen_next = plen_inc;
                    end
                    else
                    begin
                        push0    = 1'b1;
                        res0     = num_tok;
                        do_start = 1'b1;
                    end
                end
                stt_pkg::MODE_WORD:
                begin
                    if (is_alpha || is_digit)
                    begin
                        prefix_we = plen_reg < 16'(KEYWORD_CHARS);
                        plen_next = plen_inc;
                    end
                    else
                    begin
                        push0    = 1'b1;
                        res0     = word_tok;
                        do_start = 1'b1;
                    end
                end
                stt_pkg::MODE_STRING, stt_pkg::MODE_COMMENT:
                begin
                    if (( mode_reg == stt_pkg::MODE_STRING && b == stt_pkg::CHAR_QUOTE) ||
                        ( mode_reg == stt_pkg::MODE_COMMENT && b == stt_pkg::CHAR_TILDE))
                    begin
                        push0     = 1'b1;
                        res0      = stt_pkg::make_token(
                                        (mode_reg == stt_pkg::MODE_STRING) ?
                                        stt_pkg::KIND_STRING : stt_pkg::KIND_COMMENT,
                                        32'(pstart_reg), plen_reg, '0, 1'b0, 1'b0);
                        mode_next = stt_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        plen_next = plen_inc;
                    end
                end
                default:
                begin
                    do_start = 1'b1;
                end
            endcase

            if (do_start)
            begin
                mode_next = stt_pkg::MODE_IDLE;
                if (is_space)
                begin
                    start_emit = 1'b0;
                end
                else if (punct.hit)
                begin
                    start_emit = 1'b1;
                    start_tok  = stt_pkg::make_token(punct.kind, 32'(pos_reg), 16'd1,
                                                     '0, 1'b0, 1'b0);
                end
                else if (is_digit)
                begin
                    mode_next   = stt_pkg::MODE_NUMBER;
                    pstart_next = pos_reg;
                    plen_next   = 16'd1;
                    acc_next    = 31'(digit);
                    ovf_next    = 1'b0;
                end
                else if (is_alpha)
                begin
                    mode_next   = stt_pkg::MODE_WORD;
                    pstart_next = pos_reg;
                    plen_next   = 16'd1;
                    prefix_we   = 1'b1;
                    prefix_idx  = '0;
                end
                else if (b == stt_pkg::CHAR_QUOTE || b == stt_pkg::CHAR_TILDE)
                begin
                    mode_next   = (b == stt_pkg::CHAR_QUOTE) ? stt_pkg::MODE_STRING :
                                                               stt_pkg::MODE_COMMENT;
                    pstart_next = pos_reg + OFFSET_BITS'(1);
                    plen_next   = '0;
                end
                else
                begin
                    start_emit = 1'b1;
                end

                if (start_emit)
                begin
                    if (push0)
                    begin
                        push1 = 1'b1;
                        res1  = start_tok;
                    end
                    else
                    begin
                        push0 = 1'b1;
                        res0  = start_tok;
                    end
                end
            end
        end

        res0.last = !push1;
        res1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= stt_pkg::MODE_IDLE;
            pos_reg    <= '0;
            pstart_reg <= '0;
            plen_reg   <= '0;
            acc_reg    <= '0;
            ovf_reg    <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            pstart_reg <= pstart_next;
            plen_reg   <= plen_next;
            acc_reg    <= acc_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && prefix_we)
        begin
            prefix_reg[prefix_idx] <= b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && push0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (accept && push1)
        begin
            queue_reg[wr_ptr_reg + Q_PTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(accept && push0) + Q_PTR_W'(accept && push1);
            rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(pop);
            count_reg  <= count_reg + Q_CNT_W'(accept && push0) + Q_CNT_W'(accept && push1)
                          - Q_CNT_W'(pop);
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= Q_CNT_W'(Q_DEPTH))
        else $error("Token queue holds more entries than it has.");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_req.op == stt_pkg::OP_END |=> token_valid)
        else $error("End of input produced no token.");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && byte_req.op == stt_pkg::OP_END |=>
            mode_reg == stt_pkg::MODE_IDLE && pos_reg == '0)
        else $error("End of input did not return the scanner to its start.");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept && push1 |-> push0 && !res0.last)
        else $error("Second token queued without a first one.");
`endif

endmodule
